>>> design/vmla_pkg.sv
// Shared types and constants for the look-at view matrix unit.
package vmla_pkg;

    localparam int DATA_W     = 32;
    localparam int IN_W       = 9 * DATA_W;
    localparam int OUT_W      = 4 * DATA_W;
    localparam int USER_W     = 3;
    localparam int FRAC_POS   = 30;
    localparam int ROOT_STEPS = 32;
    localparam int QUO_BITS   = 31;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [1:0]  COL_LAST = 2'd3;
    localparam int          DEG_BIT  = 2;

    typedef struct packed {
        logic [3:0][3:0][31:0] col;    // col[c][r], row 0 lowest
        logic                  degen;
    } mat_rec_t;

endpackage

>>> design/vmla_norm.sv
// Pipelined vector normalizer: align, sum of squares, square root, divide.
module vmla_norm #(
    parameter int IW = 33,
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0][IW-1:0] in_vec,
    input  logic [SW-1:0]      in_side,
    output logic               out_valid,
    output logic [2:0][31:0]   out_vec,
    output logic               out_zero,
    output logic [SW-1:0]      out_side
);
    import vmla_pkg::*;

    localparam int PW = $clog2(IW);

    // magnitude stage
    logic [2:0][IW-1:0] a_mag_reg;
    logic [2:0]         a_neg_reg;
    logic [SW-1:0]      a_side_reg;
    logic               a_v_reg;
    // leading-one stage
    logic [IW-1:0]      b_or;
    logic [PW-1:0]      b_pos;
    logic [2:0][IW-1:0] b_mag_reg;
    logic [2:0]         b_neg_reg;
    logic [PW-1:0]      b_pos_reg;
    logic               b_zero_reg;
    logic [SW-1:0]      b_side_reg;
    logic               b_v_reg;
    // align stage
    logic [2:0][IW-1:0] c_sh;
    logic [2:0][30:0]   c_a_reg;
    logic [2:0]         c_neg_reg;
    logic               c_zero_reg;
    logic [SW-1:0]      c_side_reg;
    logic               c_v_reg;
    // square stage
    logic [2:0][61:0]   d_sq_reg;
    logic [2:0][30:0]   d_a_reg;
    logic [2:0]         d_neg_reg;
    logic               d_zero_reg;
    logic [SW-1:0]      d_side_reg;
    logic               d_v_reg;
    // root pipeline, index 0 holds the sum
    logic [63:0]        sr_rem  [ROOT_STEPS+1];
    logic [63:0]        sr_res  [ROOT_STEPS+1];
    logic [2:0][30:0]   sr_a    [ROOT_STEPS+1];
    logic [2:0]         sr_neg  [ROOT_STEPS+1];
    logic               sr_zero [ROOT_STEPS+1];
    logic [SW-1:0]      sr_side [ROOT_STEPS+1];
    logic               sr_v    [ROOT_STEPS+1];
    // divide pipeline, index 0 is the unregistered entry
    logic [2:0][31:0]   dv_rem  [QUO_BITS+1];
    logic [2:0][30:0]   dv_q    [QUO_BITS+1];
    logic [2:0]         dv_lsb  [QUO_BITS+1];
    logic [31:0]        dv_len  [QUO_BITS+1];
    logic [2:0]         dv_neg  [QUO_BITS+1];
    logic               dv_zero [QUO_BITS+1];
    logic [SW-1:0]      dv_side [QUO_BITS+1];
    logic               dv_v    [QUO_BITS+1];
    logic               out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            sr_v[0]   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg   <= in_valid;
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            d_v_reg   <= c_v_reg;
            sr_v[0]   <= d_v_reg;
            out_v_reg <= dv_v[QUO_BITS];
        end
    end

    always_comb
    begin
        b_or  = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];
        b_pos = '0;
        for (int k = 0; k < IW; k++)
        begin
            if (b_or[k])
                b_pos = PW'(k);
        end
    end

    // truncate right or widen left so the largest magnitude sits at bit 30
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg >= PW'(FRAC_POS))
                c_sh[i] = b_mag_reg[i] >> (b_pos_reg - PW'(FRAC_POS));
            else
                c_sh[i] = b_mag_reg[i] << (PW'(FRAC_POS) - b_pos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_neg_reg[i] <= in_vec[i][IW-1];
                a_mag_reg[i] <= in_vec[i][IW-1] ? (~in_vec[i] + IW'(1)) : in_vec[i];
                c_a_reg[i]   <= c_sh[i][30:0];
                d_sq_reg[i]  <= c_a_reg[i] * c_a_reg[i];
            end
            a_side_reg <= in_side;
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_pos_reg  <= b_pos;
            b_zero_reg <= (b_or == '0);
            b_side_reg <= a_side_reg;
            c_neg_reg  <= b_neg_reg;
            c_zero_reg <= b_zero_reg;
            c_side_reg <= b_side_reg;
            d_a_reg    <= c_a_reg;
            d_neg_reg  <= c_neg_reg;
            d_zero_reg <= c_zero_reg;
            d_side_reg <= c_side_reg;
            sr_rem[0]  <= 64'(d_sq_reg[0]) + 64'(d_sq_reg[1]) + 64'(d_sq_reg[2]);
            sr_res[0]  <= '0;
            sr_a[0]    <= d_a_reg;
            sr_neg[0]  <= d_neg_reg;
            sr_zero[0] <= d_zero_reg;
            sr_side[0] <= d_side_reg;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
        logic [64:0] trial;

        assign trial = {1'b0, sr_res[k]} + {1'b0, RBIT};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sr_v[k+1] <= 1'b0;
            else if (en)
                sr_v[k+1] <= sr_v[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, sr_rem[k]} >= trial)
                begin
                    sr_rem[k+1] <= sr_rem[k] - trial[63:0];
                    sr_res[k+1] <= (sr_res[k] >> 1) + RBIT;
                end
                else
                begin
                    sr_rem[k+1] <= sr_rem[k];
                    sr_res[k+1] <= sr_res[k] >> 1;
                end
                sr_a[k+1]    <= sr_a[k];
                sr_neg[k+1]  <= sr_neg[k];
                sr_zero[k+1] <= sr_zero[k];
                sr_side[k+1] <= sr_side[k];
            end
        end
    end

    // the top quotient bits are known zero, so start from magnitude >> 1
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_rem[0][i] = {2'b00, sr_a[ROOT_STEPS][i][30:1]};
            dv_lsb[0][i] = sr_a[ROOT_STEPS][i][0];
        end
        dv_q[0]    = '0;
        dv_len[0]  = sr_res[ROOT_STEPS][31:0];
        dv_neg[0]  = sr_neg[ROOT_STEPS];
        dv_zero[0] = sr_zero[ROOT_STEPS];
        dv_side[0] = sr_side[ROOT_STEPS];
        dv_v[0]    = sr_v[ROOT_STEPS];
    end

    // one quotient bit per stage, three lanes share the divisor
    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        logic [2:0][32:0] shl;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
                shl[i] = {dv_rem[j][i], dv_lsb[j][i]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v[j+1] <= 1'b0;
            else if (en)
                dv_v[j+1] <= dv_v[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (shl[i] >= {1'b0, dv_len[j]})
                    begin
                        dv_rem[j+1][i] <= 32'(shl[i] - {1'b0, dv_len[j]});
                        dv_q[j+1][i]   <= {dv_q[j][i][29:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem[j+1][i] <= shl[i][31:0];
                        dv_q[j+1][i]   <= {dv_q[j][i][29:0], 1'b0};
                    end
                end
                dv_lsb[j+1]  <= '0;
                dv_len[j+1]  <= dv_len[j];
                dv_neg[j+1]  <= dv_neg[j];
                dv_zero[j+1] <= dv_zero[j];
                dv_side[j+1] <= dv_side[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_neg[QUO_BITS][i])
                    out_vec[i] <= ~{1'b0, dv_q[QUO_BITS][i]} + 32'd1;
                else
                    out_vec[i] <= {1'b0, dv_q[QUO_BITS][i]};
            end
            out_zero <= dv_zero[QUO_BITS];
            out_side <= dv_side[QUO_BITS];
        end
    end

    assign out_valid = out_v_reg;

endmodule

>>> design/vmla_front.sv
// Front pipeline: forward, right and true-up vectors and the matrix entries.
module vmla_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [vmla_pkg::IN_W-1:0]  in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output vmla_pkg::mat_rec_t         out_rec
);
    import vmla_pkg::*;

    localparam logic signed [63:0] SAT_HI  = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO  = -64'sd2147483648;
    localparam logic signed [63:0] UNIT_HI = 64'sd1073741824;
    localparam logic signed [63:0] UNIT_LO = -64'sd1073741824;

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int unsigned n);
        logic [63:0] mag;
        logic [63:0] r;
        mag = x[63] ? (~x + 64'd1) : x;
        r   = (mag + (64'd1 << (n - 1))) >> n;
        rnd_shift = x[63] ? $signed(~r + 64'd1) : $signed(r);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > SAT_HI)
            sat32 = SAT_HI[31:0];
        else if (x < SAT_LO)
            sat32 = SAT_LO[31:0];
        else
            sat32 = x[31:0];
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        smul = a * b;
    endfunction

    function automatic logic signed [63:0] sx(input logic [31:0] a);
        sx = 64'($signed(a));
    endfunction

    logic en;

    logic [2:0][32:0]  f0_d_reg;
    logic [2:0][31:0]  f0_eye_reg, f0_up_reg;
    logic              f0_v_reg;

    logic              n1_v, n1_zero;
    logic [2:0][31:0]  n1_fwd;
    logic [191:0]      n1_side;
    logic [2:0][31:0]  n1_eye, n1_up;

    logic [5:0][63:0]  f1_p_reg;
    logic [2:0][31:0]  f1_eye_reg, f1_fwd_reg;
    logic              f1_zero_reg, f1_v_reg;

    logic [2:0][63:0]  f2_rc_reg;
    logic [2:0][31:0]  f2_eye_reg, f2_fwd_reg;
    logic              f2_zero_reg, f2_v_reg;

    logic              n2_v, n2_zero;
    logic [2:0][31:0]  n2_rgt;
    logic [192:0]      n2_side;
    logic [2:0][31:0]  n2_eye, n2_fwd;
    logic              n2_zero1;

    logic [5:0][63:0]  f3_t_reg;
    logic [2:0][63:0]  f3_dr_reg, f3_df_reg;
    logic [2:0][31:0]  f3_eye_reg, f3_fwd_reg, f3_rgt_reg;
    logic              f3_deg_reg, f3_v_reg;

    logic [2:0][63:0]  f4_tr_reg;
    logic [63:0]       f4_dr_reg, f4_df_reg;
    logic [2:0][31:0]  f4_eye_reg, f4_fwd_reg, f4_rgt_reg;
    logic              f4_deg_reg, f4_v_reg;

    logic signed [63:0] f5_t [3];
    logic [2:0][31:0]  f5_tu_reg;
    logic [63:0]       f5_dr_reg, f5_df_reg;
    logic [2:0][31:0]  f5_eye_reg, f5_fwd_reg, f5_rgt_reg;
    logic              f5_deg_reg, f5_v_reg;

    logic [2:0][63:0]  f6_du_reg;
    logic [2:0][31:0]  f6_tu_reg, f6_fwd_reg, f6_rgt_reg;
    logic [63:0]       f6_dr_reg, f6_df_reg;
    logic              f6_deg_reg, f6_v_reg;

    logic [63:0]       f7_du_reg, f7_dr_reg, f7_df_reg;
    logic [2:0][31:0]  f7_tu_reg, f7_fwd_reg, f7_rgt_reg;
    logic              f7_deg_reg, f7_v_reg;

    mat_rec_t          f8_next;
    mat_rec_t          f8_rec_reg;
    logic              f8_v_reg;

    // the whole pipeline holds while the queue refuses the finished matrix
    assign en       = !f8_v_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
            f5_v_reg <= 1'b0;
            f6_v_reg <= 1'b0;
            f7_v_reg <= 1'b0;
            f8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f0_v_reg <= in_valid;
            f1_v_reg <= n1_v;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= n2_v;
            f4_v_reg <= f3_v_reg;
            f5_v_reg <= f4_v_reg;
            f6_v_reg <= f5_v_reg;
            f7_v_reg <= f6_v_reg;
            f8_v_reg <= f7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f0_eye_reg[i] <= in_data[32*i +: 32];
                f0_up_reg[i]  <= in_data[192 + 32*i +: 32];
                f0_d_reg[i]   <= 33'($signed(in_data[96 + 32*i +: 32]))
                               - 33'($signed(in_data[32*i +: 32]));
            end
        end
    end

    vmla_norm #(
        .IW (33),
        .SW (192)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f0_v_reg),
        .in_vec    (f0_d_reg),
        .in_side   ({f0_up_reg, f0_eye_reg}),
        .out_valid (n1_v),
        .out_vec   (n1_fwd),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    assign n1_eye = n1_side[95:0];
    assign n1_up  = n1_side[191:96];

    // forward x up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_p_reg[0] <= smul(n1_fwd[1], n1_up[2]);
            f1_p_reg[1] <= smul(n1_fwd[2], n1_up[1]);
            f1_p_reg[2] <= smul(n1_fwd[2], n1_up[0]);
            f1_p_reg[3] <= smul(n1_fwd[0], n1_up[2]);
            f1_p_reg[4] <= smul(n1_fwd[0], n1_up[1]);
            f1_p_reg[5] <= smul(n1_fwd[1], n1_up[0]);
            f1_eye_reg  <= n1_eye;
            f1_fwd_reg  <= n1_fwd;
            f1_zero_reg <= n1_zero;

            f2_rc_reg[0] <= f1_p_reg[0] - f1_p_reg[1];
            f2_rc_reg[1] <= f1_p_reg[2] - f1_p_reg[3];
            f2_rc_reg[2] <= f1_p_reg[4] - f1_p_reg[5];
            f2_eye_reg   <= f1_eye_reg;
            f2_fwd_reg   <= f1_fwd_reg;
            f2_zero_reg  <= f1_zero_reg;
        end
    end

    vmla_norm #(
        .IW (64),
        .SW (193)
    ) u_norm_rgt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f2_v_reg),
        .in_vec    (f2_rc_reg),
        .in_side   ({f2_zero_reg, f2_fwd_reg, f2_eye_reg}),
        .out_valid (n2_v),
        .out_vec   (n2_rgt),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    assign n2_eye   = n2_side[95:0];
    assign n2_fwd   = n2_side[191:96];
    assign n2_zero1 = n2_side[192];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f5_t[i] = rnd_shift($signed(f4_tr_reg[i]), 30);
            if (f5_t[i] > UNIT_HI)
                f5_t[i] = UNIT_HI;
            if (f5_t[i] < UNIT_LO)
                f5_t[i] = UNIT_LO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // right x forward and the translation products
            f3_t_reg[0] <= smul(n2_rgt[1], n2_fwd[2]);
            f3_t_reg[1] <= smul(n2_rgt[2], n2_fwd[1]);
            f3_t_reg[2] <= smul(n2_rgt[2], n2_fwd[0]);
            f3_t_reg[3] <= smul(n2_rgt[0], n2_fwd[2]);
            f3_t_reg[4] <= smul(n2_rgt[0], n2_fwd[1]);
            f3_t_reg[5] <= smul(n2_rgt[1], n2_fwd[0]);
            for (int i = 0; i < 3; i++)
            begin
                f3_dr_reg[i] <= smul(n2_rgt[i], n2_eye[i]);
                f3_df_reg[i] <= smul(n2_fwd[i], n2_eye[i]);
            end
            f3_eye_reg <= n2_eye;
            f3_fwd_reg <= n2_fwd;
            f3_rgt_reg <= n2_rgt;
            f3_deg_reg <= n2_zero1 || n2_zero;

            f4_tr_reg[0] <= f3_t_reg[0] - f3_t_reg[1];
            f4_tr_reg[1] <= f3_t_reg[2] - f3_t_reg[3];
            f4_tr_reg[2] <= f3_t_reg[4] - f3_t_reg[5];
            f4_dr_reg    <= f3_dr_reg[0] + f3_dr_reg[1] + f3_dr_reg[2];
            f4_df_reg    <= f3_df_reg[0] + f3_df_reg[1] + f3_df_reg[2];
            f4_eye_reg   <= f3_eye_reg;
            f4_fwd_reg   <= f3_fwd_reg;
            f4_rgt_reg   <= f3_rgt_reg;
            f4_deg_reg   <= f3_deg_reg;

            for (int i = 0; i < 3; i++)
                f5_tu_reg[i] <= f5_t[i][31:0];
            f5_dr_reg  <= f4_dr_reg;
            f5_df_reg  <= f4_df_reg;
            f5_eye_reg <= f4_eye_reg;
            f5_fwd_reg <= f4_fwd_reg;
            f5_rgt_reg <= f4_rgt_reg;
            f5_deg_reg <= f4_deg_reg;

            for (int i = 0; i < 3; i++)
                f6_du_reg[i] <= smul(f5_tu_reg[i], f5_eye_reg[i]);
            f6_tu_reg  <= f5_tu_reg;
            f6_fwd_reg <= f5_fwd_reg;
            f6_rgt_reg <= f5_rgt_reg;
            f6_dr_reg  <= f5_dr_reg;
            f6_df_reg  <= f5_df_reg;
            f6_deg_reg <= f5_deg_reg;

            f7_du_reg  <= f6_du_reg[0] + f6_du_reg[1] + f6_du_reg[2];
            f7_tu_reg  <= f6_tu_reg;
            f7_fwd_reg <= f6_fwd_reg;
            f7_rgt_reg <= f6_rgt_reg;
            f7_dr_reg  <= f6_dr_reg;
            f7_df_reg  <= f6_df_reg;
            f7_deg_reg <= f6_deg_reg;

            f8_rec_reg <= f8_next;
        end
    end

    always_comb
    begin
        f8_next.degen = f7_deg_reg;
        if (f7_deg_reg)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    f8_next.col[c][r] = (c == r) ? ONE_Q16 : '0;
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                f8_next.col[c][0] = sat32(rnd_shift(sx(f7_rgt_reg[c]), 14));
                f8_next.col[c][1] = sat32(rnd_shift(sx(f7_tu_reg[c]), 14));
                f8_next.col[c][2] = sat32(rnd_shift(-sx(f7_fwd_reg[c]), 14));
                f8_next.col[c][3] = '0;
            end
            f8_next.col[3][0] = sat32(rnd_shift(-$signed(f7_dr_reg), 30));
            f8_next.col[3][1] = sat32(rnd_shift(-$signed(f7_du_reg), 30));
            f8_next.col[3][2] = sat32(rnd_shift($signed(f7_df_reg), 30));
            f8_next.col[3][3] = ONE_Q16;
        end
    end

    assign out_valid = f8_v_reg;
    assign out_rec   = f8_rec_reg;

endmodule

>>> design/vmla_queue.sv
// Short FIFO of finished matrices between the front pipeline and the column emitter.
module vmla_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vmla_pkg::mat_rec_t in_rec,
    output logic               out_valid,
    input  logic               out_ready,
    output vmla_pkg::mat_rec_t out_rec
);
    import vmla_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mat_rec_t        ent_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            wr, rd;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_rec   = ent_reg[rd_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            if (rd)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            if (wr && !rd)
                cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (rd && !wr)
                cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            ent_reg[wr_reg] <= in_rec;
    end

endmodule

>>> design/vmla_back.sv
// Column emitter: streams the queued matrix out one column per transfer.
module vmla_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  vmla_pkg::mat_rec_t          q_rec,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [vmla_pkg::OUT_W-1:0]  m_tdata,
    output logic [vmla_pkg::USER_W-1:0] m_tuser,
    output logic                        m_tlast
);
    import vmla_pkg::*;

    logic [1:0]         col_reg;
    logic               tvalid_reg;
    logic [OUT_W-1:0]   tdata_reg;
    logic [USER_W-1:0]  tuser_reg;
    logic               tlast_reg;
    logic               load;

    assign load  = q_valid && (!tvalid_reg || m_tready);
    // release the matrix once its last column is loaded
    assign q_pop = load && (col_reg == COL_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            if (!tvalid_reg || m_tready)
                tvalid_reg <= q_valid;
            if (load)
                col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= q_rec.col[col_reg];
            tuser_reg <= {q_rec.degen, col_reg};
            tlast_reg <= (col_reg == COL_LAST);
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

>>> design/view_matrix_look_at_unit.sv
// Top level of the right-handed look-at view matrix unit.
//
// Slave channel: one transfer carries eye, target and up (nine signed Q16.16
// words). Master channel: four transfers per input, one matrix column each,
// column 0 first, tlast on column 3, tuser giving the column number and a
// flag that marks the identity matrix forced by a zero-length vector.
// A fully pipelined front computes the matrix: two normalizers, each with a
// 32-stage square root and a 31-stage divider, plus cross and dot products.
// With no stall the first column leaves once the input has passed the front
// pipeline, the queue and the emitter's output register; the other three
// follow back to back. The input rate is limited by the single master
// channel, which moves one column per transfer; inputs are taken back to back
// while earlier ones are still in the front pipeline, until the queue fills.
// A short queue of finished matrices sits between the front and the column
// emitter. When the receiver stalls, the emitter holds its output register,
// the queue fills, and then the front pipeline holds and s_tready drops.
// Reset clears all valid bits, the queue pointers and count, and the column counter; nothing else needs it.
module view_matrix_look_at_unit #(
    parameter int QUEUE_DEPTH = vmla_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [vmla_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // entry_row0, entry_row1, entry_row2, entry_row3
    output logic [vmla_pkg::OUT_W-1:0]  m_tdata,
    // column_index[1:0], degenerate
    output logic [vmla_pkg::USER_W-1:0] m_tuser,
    output logic                        m_tlast
);
    import vmla_pkg::*;

    logic     f_valid, f_ready, q_valid, q_pop;
    mat_rec_t f_rec, q_rec;

    vmla_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_rec   (f_rec)
    );

    vmla_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_rec    (f_rec),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_rec   (q_rec)
    );

    vmla_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_rec    (q_rec),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_last_on_col3: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] == COL_LAST)))
        else $error("tlast does not match the last column");

    a_next_col: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1)
         && (m_tuser[DEG_BIT] == $past(m_tuser[DEG_BIT]))))
        else $error("columns of one matrix are not emitted in sequence");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[DEG_BIT] && (m_tuser[1:0] == COL_LAST)) |->
        (m_tdata == {ONE_Q16, 96'd0}))
        else $error("degenerate matrix is not the identity");

endmodule

>>> tb/sv/view_matrix_look_at_unit_test.sv
// Testbench for the look-at view matrix unit: scoreboard against a bit-exact predictor.
module view_matrix_look_at_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vmla_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int HOLD_CYCLES    = 600;

    typedef struct packed {
        logic [31:0] row0;
        logic [31:0] row1;
        logic [31:0] row2;
        logic [31:0] row3;
        logic [1:0]  col_idx;
        logic        degen;
        logic        last;
    } column_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic [USER_W-1:0]   m_tuser;
    logic                m_tlast;

    logic [IN_W-1:0] pending_inputs[$];
    column_t         expected_columns[$];
    int              errors;
    int              idle_cnt;
    bit              calm;       // no idling at all
    bit              hold_rx;    // receiver holds off
    bit              pause_tx;   // sender waits for drain
    bit              stim_done;

    view_matrix_look_at_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint rnd_shift(longint x, int n);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (longint'(1) <<< (n - 1))) >>> n;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic logic [31:0] clamp_q16(longint x);
        if (x > 64'sd2147483647)
            x = 64'sd2147483647;
        if (x < -64'sd2147483648)
            x = -64'sd2147483648;
        return x[31:0];
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Unit vector in Q2.30; returns 0 for zero length.
    function automatic bit unit_vec(input longint v[3], output longint u[3]);
        longint unsigned a[3], mx, sum, len, q;
        bit neg[3];
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            a[i] = neg[i] ? -v[i] : v[i];
            if (a[i] > mx)
                mx = a[i];
        end
        if (mx == 0)
            return 1'b0;
        while (mx >= (64'd1 << 31))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                a[i] >>= 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                a[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += a[i] * a[i];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (a[i] << 30) / len;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic longint dot3(longint a[3], longint b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    task automatic predict_view_matrix(input logic [IN_W-1:0] item);
        longint eye[3], tgt[3], upv[3], dir[3], fwd[3], rc[3], rgt[3], tu[3];
        logic [31:0] m[16];
        bit ok;
        column_t col;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(item[32*i +: 32]));
            tgt[i] = longint'($signed(item[32*(3+i) +: 32]));
            upv[i] = longint'($signed(item[32*(6+i) +: 32]));
            dir[i] = tgt[i] - eye[i];
        end
        ok = unit_vec(dir, fwd);
        if (ok)
        begin
            cross3(fwd, upv, rc);
            ok = unit_vec(rc, rgt);
        end
        if (!ok)
        begin
            for (int i = 0; i < 16; i++)
                m[i] = (i % 5 == 0) ? ONE_Q16 : 32'd0;
        end
        else
        begin
            cross3(rgt, fwd, tu);
            for (int i = 0; i < 3; i++)
            begin
                tu[i] = rnd_shift(tu[i], 30);
                if (tu[i] > 64'sd1073741824)
                    tu[i] = 64'sd1073741824;
                if (tu[i] < -64'sd1073741824)
                    tu[i] = -64'sd1073741824;
            end
            for (int c = 0; c < 3; c++)
            begin
                m[c*4+0] = clamp_q16(rnd_shift(rgt[c], 14));
                m[c*4+1] = clamp_q16(rnd_shift(tu[c], 14));
                m[c*4+2] = clamp_q16(rnd_shift(-fwd[c], 14));
                m[c*4+3] = 32'd0;
            end
            m[12] = clamp_q16(rnd_shift(-dot3(rgt, eye), 30));
            m[13] = clamp_q16(rnd_shift(-dot3(tu, eye), 30));
            m[14] = clamp_q16(rnd_shift(dot3(fwd, eye), 30));
            m[15] = ONE_Q16;
        end
        for (int c = 0; c < 4; c++)
        begin
            col.row0    = m[c*4+0];
            col.row1    = m[c*4+1];
            col.row2    = m[c*4+2];
            col.row3    = m[c*4+3];
            col.col_idx = c[1:0];
            col.degen   = !ok;
            col.last    = (c == 3);
            expected_columns.push_back(col);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return $urandom;
            2: return 32'($signed($urandom_range(0, 65536 * 200)) - 65536 * 100);
            default: return 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] pack9(logic [31:0] w[9]);
        logic [IN_W-1:0] r;
        for (int i = 0; i < 9; i++)
            r[32*i +: 32] = w[i];
        return r;
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_inputs.size() > 0 && !pause_tx &&
                (calm || $urandom_range(0, 99) >= 11))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_inputs.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver readiness.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_rx && (calm || $urandom_range(0, 99) >= 11);
    end

    // Monitor and scoreboard.
    always @(posedge clk)
    begin
        column_t got, want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_view_matrix(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.row0    = m_tdata[31:0];
                got.row1    = m_tdata[63:32];
                got.row2    = m_tdata[95:64];
                got.row3    = m_tdata[127:96];
                got.col_idx = m_tuser[1:0];
                got.degen   = m_tuser[DEG_BIT];
                got.last    = m_tlast;
                if (expected_columns.size() == 0)
                begin
                    $display("%0t: unexpected column, actual %h", $realtime, got);
                    errors++;
                end
                else
                begin
                    want = expected_columns.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: column mismatch, expected %h actual %h",
                                 $realtime, want, got);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] w[9];
        errors    = 0;
        idle_cnt  = 0;
        calm      = 1'b0;
        hold_rx   = 1'b0;
        pause_tx  = 1'b0;
        stim_done = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;

        // Directed: basic view, eye at target, up zero, up parallel, extremes.
        w = '{0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0};
        pending_inputs.push_back(pack9(w));
        w = '{32'h0001_0000, 2, 3, 32'h0001_0000, 2, 3, 0, 32'h0001_0000, 0};
        pending_inputs.push_back(pack9(w));
        w = '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0};
        pending_inputs.push_back(pack9(w));
        w = '{0, 0, 0, 32'h0003_0000, 0, 0, 32'hfffe_0000, 0, 0};
        pending_inputs.push_back(pack9(w));
        w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0};
        pending_inputs.push_back(pack9(w));
        w = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        pending_inputs.push_back(pack9(w));
        w = '{32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000, 0, 0, 1,
              0, 32'h0001_0000, 0};
        pending_inputs.push_back(pack9(w));
        w = '{32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 1};
        pending_inputs.push_back(pack9(w));
        w = '{0, 0, 0, 1, 1, 0, 1, 1, 1};
        pending_inputs.push_back(pack9(w));
        for (int n = 0; n < 420; n++)
        begin
            for (int i = 0; i < 9; i++)
                w[i] = rand_word();
            if ($urandom_range(0, 19) == 0)
                for (int i = 0; i < 3; i++)
                    w[3+i] = w[i];
            else if ($urandom_range(0, 19) == 0)
                for (int i = 0; i < 3; i++)
                    w[6+i] = w[3+i] - w[i];
            pending_inputs.push_back(pack9(w));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Receiver holds off while the sender keeps offering.
        wait (pending_inputs.size() < 400);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;

        // Sender pauses until every result is in.
        wait (pending_inputs.size() < 300);
        pause_tx = 1'b1;
        wait (expected_columns.size() == 0 && !s_tvalid);
        @(posedge clk);
        pause_tx = 1'b0;

        // Stretch with no idling.
        wait (pending_inputs.size() < 200);
        calm = 1'b1;
        wait (pending_inputs.size() < 120);
        calm = 1'b0;

        wait (pending_inputs.size() == 0 && !s_tvalid);
        stim_done = 1'b1;
        wait (expected_columns.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_columns.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
design/vmla_pkg.sv
design/vmla_norm.sv
design/vmla_front.sv
design/vmla_queue.sv
design/vmla_back.sv
design/view_matrix_look_at_unit.sv
tb/sv/view_matrix_look_at_unit_test.sv
